>>> rtl/elq_pkg.sv
// ============================================================================
// elq_pkg: shared types and constants of the error-bounded linear quantizer
// Widths, configuration register indexes, pipeline depth and the item record
// that travels down the pipeline.
// ============================================================================
package elq_pkg;

    // Sample and prediction width (two's complement).
    localparam int DATA_WIDTH = 32;

    // Configuration register widths and limits.
    localparam int BOUND_W    = 31;
    localparam int CAP_W      = 17;
    localparam int CFG_DATA_W = (BOUND_W > CAP_W) ? BOUND_W : CAP_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(65536);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_BOUND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(1);

    // Result widths.
    localparam int CODE_W  = 17;
    localparam int RECON_W = 33;

    // Inside the radius the quotient d / bound is below the largest capacity.
    localparam int Q_W    = $clog2(CAP_MAX);
    localparam int PROD_W = BOUND_W + Q_W;

    // Pipeline depth: front end, one divider stage per quotient bit, back end.
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 2;
    localparam int LATENCY      = FRONT_STAGES + Q_W + BACK_STAGES;

    // Effective configuration after zero-bound and capacity clamping.
    typedef struct packed {
        logic [BOUND_W-1:0] bound;
        logic [Q_W-1:0]     cap_m1;
        logic [CAP_W-1:0]   half;
    } t_cfg;

    // One item in flight through the divider.
    typedef struct packed {
        logic                         up;
        logic                         unpred;
        logic signed [DATA_WIDTH-1:0] sample;
        logic signed [DATA_WIDTH-1:0] pred;
        logic [DATA_WIDTH-1:0]        rem;
        logic [Q_W-1:0]               quo;
    } t_item;

endpackage

>>> rtl/elq_cfg.sv
// ============================================================================
// elq_cfg: configuration registers
// Holds the error bound and the bin capacity and derives the effective
// bound, capacity minus one and half capacity.
// ============================================================================
module elq_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [elq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [elq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output elq_pkg::t_cfg                   o_cfg
);

    logic [elq_pkg::BOUND_W-1:0] r_err_bound;
    logic [elq_pkg::CAP_W-1:0]   r_capacity;
    logic [elq_pkg::CAP_W-1:0]   cap;
    logic [elq_pkg::CAP_W-1:0]   cap_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_bound <= elq_pkg::BOUND_W'(1);
            r_capacity  <= elq_pkg::CAP_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                elq_pkg::CFG_ERR_BOUND: r_err_bound <= i_cfg_data[elq_pkg::BOUND_W-1:0];
                elq_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data[elq_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_capacity < elq_pkg::CAP_MIN) begin
            cap = elq_pkg::CAP_MIN;
        end else if (r_capacity > elq_pkg::CAP_MAX) begin
            cap = elq_pkg::CAP_MAX;
        end else begin
            cap = r_capacity;
        end
        cap_dec = cap - elq_pkg::CAP_W'(1);

        // A zero bound behaves as a bound of one.
        o_cfg.bound  = (r_err_bound == '0) ? elq_pkg::BOUND_W'(1) : r_err_bound;
        o_cfg.cap_m1 = cap_dec[elq_pkg::Q_W-1:0];
        o_cfg.half   = cap >> 1;
    end

endmodule

>>> rtl/elq_front.sv
// ============================================================================
// elq_front: difference, magnitude and radius check
// Three stages: signed difference, magnitude and radius product, then the
// radius compare that marks an item unpredictable.
// ============================================================================
module elq_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  elq_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    input  logic signed [elq_pkg::DATA_WIDTH-1:0] i_sample,
    input  logic signed [elq_pkg::DATA_WIDTH-1:0] i_pred,
    output logic                                o_valid,
    output elq_pkg::t_item                      o_item
);

    localparam int DW = elq_pkg::DATA_WIDTH;

    // Stage 1.
    logic                 r_v1;
    logic signed [DW-1:0] r_s1;
    logic signed [DW-1:0] r_p1;
    logic signed [DW:0]   r_diff1;
    logic signed [DW:0]   n_diff1;

    // Stage 2.
    logic                         r_v2;
    logic signed [DW-1:0]         r_s2;
    logic signed [DW-1:0]         r_p2;
    logic                         r_up2;
    logic [DW-1:0]                r_d2;
    logic [elq_pkg::PROD_W-1:0]   r_rad2;
    logic signed [DW:0]           neg_diff;
    logic                         n_up2;
    logic [DW-1:0]                n_d2;
    logic [elq_pkg::PROD_W-1:0]   n_rad2;

    // Stage 3.
    logic           r_v3;
    elq_pkg::t_item r_item3;
    elq_pkg::t_item n_item3;

    assign n_diff1 = (DW+1)'(i_sample) - (DW+1)'(i_pred);

    always_comb begin
        neg_diff = -r_diff1;
        n_up2    = ~r_diff1[DW];
        n_d2     = n_up2 ? r_diff1[DW-1:0] : neg_diff[DW-1:0];
        n_rad2   = elq_pkg::PROD_W'(i_cfg.cap_m1) * elq_pkg::PROD_W'(i_cfg.bound);
    end

    always_comb begin
        n_item3.up     = r_up2;
        n_item3.unpred = elq_pkg::PROD_W'(r_d2) > r_rad2;
        n_item3.sample = r_s2;
        n_item3.pred   = r_p2;
        n_item3.rem    = r_d2;
        n_item3.quo    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1    <= i_sample;
        r_p1    <= i_pred;
        r_diff1 <= n_diff1;
        r_s2    <= r_s1;
        r_p2    <= r_p1;
        r_up2   <= n_up2;
        r_d2    <= n_d2;
        r_rad2  <= n_rad2;
        r_item3 <= n_item3;
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;

endmodule

>>> rtl/elq_divider.sv
// ============================================================================
// elq_divider: pipelined restoring divider
// One quotient bit per stage, most significant first. The quotient is exact
// whenever the magnitude lies inside the radius.
// ============================================================================
module elq_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  elq_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  elq_pkg::t_item i_item,
    output logic           o_valid,
    output elq_pkg::t_item o_item
);

    localparam int QW = elq_pkg::Q_W;
    localparam int PW = elq_pkg::PROD_W;

    logic           r_valid [QW];
    elq_pkg::t_item r_item  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int SHIFT = QW - 1 - k;

        logic           v_in;
        elq_pkg::t_item it_in;
        elq_pkg::t_item n_item;
        logic [PW-1:0]  divisor;
        logic [PW:0]    trial;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign it_in = i_item;
        end else begin : g_next
            assign v_in  = r_valid[k-1];
            assign it_in = r_item[k-1];
        end

        assign divisor = PW'(i_cfg.bound) << SHIFT;
        assign trial   = (PW+1)'(it_in.rem) - (PW+1)'(divisor);

        // No borrow means the shifted divisor fits into the remainder.
        always_comb begin
            n_item = it_in;
            if (!trial[PW]) begin
                n_item.rem        = trial[elq_pkg::DATA_WIDTH-1:0];
                n_item.quo[SHIFT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_item[k] <= n_item;
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_item  = r_item[QW-1];

endmodule

>>> rtl/elq_back.sv
// ============================================================================
// elq_back: code and reconstruction
// Two stages: bin state, code and step product, then the reconstruction add
// with saturation and the final output register.
// ============================================================================
module elq_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  elq_pkg::t_cfg                        i_cfg,
    input  logic                                 i_valid,
    input  elq_pkg::t_item                       i_item,
    output logic                                 o_strobe,
    output logic [elq_pkg::CODE_W-1:0]           o_quant_code,
    output logic signed [elq_pkg::RECON_W-1:0]   o_reconstructed,
    output logic                                 o_unpredictable
);

    localparam int DW    = elq_pkg::DATA_WIDTH;
    localparam int QW    = elq_pkg::Q_W;
    localparam int PW    = elq_pkg::PROD_W;
    localparam int RW    = elq_pkg::RECON_W;
    localparam int CW    = elq_pkg::CODE_W;
    localparam int SUM_W = PW + 3;

    // Stage 1.
    logic                 r_v1;
    logic                 r_up1;
    logic                 r_unpred1;
    logic signed [DW-1:0] r_sample1;
    logic signed [DW-1:0] r_pred1;
    logic [CW-1:0]        r_code1;
    logic [PW-1:0]        r_prod1;
    logic [QW:0]          q_inc;
    logic [QW-1:0]        bin_state;
    logic [CW-1:0]        n_code1;
    logic [PW-1:0]        n_prod1;

    // Stage 2.
    logic                    r_strobe;
    logic [CW-1:0]           r_code;
    logic signed [RW-1:0]    r_recon;
    logic                    r_unpred;
    logic signed [SUM_W-1:0] pred_ext;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [RW-1:0]    sat;
    logic                    in_range;

    always_comb begin
        q_inc     = (QW+1)'(i_item.quo) + (QW+1)'(1);
        bin_state = q_inc[QW:1];
        n_code1   = i_item.up ? (i_cfg.half + CW'(bin_state))
                              : (i_cfg.half - CW'(bin_state));
        n_prod1   = PW'(bin_state) * PW'(i_cfg.bound);
    end

    always_comb begin
        pred_ext = SUM_W'(r_pred1);
        step_ext = $signed({2'b00, r_prod1, 1'b0});
        sum      = r_up1 ? (pred_ext + step_ext) : (pred_ext - step_ext);
        // The sum fits when every bit above the result's sign bit agrees.
        in_range = (sum[SUM_W-1:RW-1] == '0) || (sum[SUM_W-1:RW-1] == '1);
        if (in_range) begin
            sat = sum[RW-1:0];
        end else if (sum[SUM_W-1]) begin
            sat = {1'b1, {(RW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(RW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= i_valid;
            r_strobe <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up1     <= i_item.up;
        r_unpred1 <= i_item.unpred;
        r_sample1 <= i_item.sample;
        r_pred1   <= i_item.pred;
        r_code1   <= n_code1;
        r_prod1   <= n_prod1;
        r_unpred  <= r_unpred1;
        r_code    <= r_unpred1 ? '0 : r_code1;
        r_recon   <= r_unpred1 ? RW'(r_sample1) : sat;
    end

    assign o_strobe        = r_strobe;
    assign o_quant_code    = r_code;
    assign o_reconstructed = r_recon;
    assign o_unpredictable = r_unpred;

endmodule

>>> rtl/error_bounded_linear_quantizer.sv
// ============================================================================
// error_bounded_linear_quantizer: fixed-point error-bounded quantizer
// Quantizes the difference between a sample and its prediction into a bin
// code and returns the value a decoder would reconstruct.
// ============================================================================
// The block takes one sample/prediction pair in every clock cycle and returns
// exactly one result per transfer, in order, once the transfer has passed
// three front-end stages, sixteen divider stages and two output stages. The
// rate of one item per cycle comes from the pipelined, sixteen-stage
// restoring divider, one quotient bit per stage. busy is high only while
// reset is asserted. The receiver cannot stall the block: each result is
// shown on the output ports for a single cycle, marked by o_strobe, and
// must be captured then. Configuration writes take effect at once and are
// to be made only when no result is still outstanding.
// ============================================================================
module error_bounded_linear_quantizer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Command interface: a transfer happens when start is high and busy low.
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [elq_pkg::DATA_WIDTH-1:0]  i_sample_value,
    input  logic signed [elq_pkg::DATA_WIDTH-1:0]  i_predicted_value,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [elq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [elq_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // Results, one cycle each.
    output logic                                   o_strobe,
    output logic [elq_pkg::CODE_W-1:0]             o_quant_code,
    output logic signed [elq_pkg::RECON_W-1:0]     o_reconstructed,
    output logic                                   o_unpredictable
);

    elq_pkg::t_cfg  cfg;
    logic           accept;
    logic           front_valid;
    elq_pkg::t_item front_item;
    logic           div_valid;
    elq_pkg::t_item div_item;

    // The pipeline never stalls, so the block is busy only during reset.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Register values are read live; the user, not the block, keeps writes to idle.
    elq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Difference, magnitude and the radius check that flags outliers.
    elq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (accept),
        .i_sample (i_sample_value),
        .i_pred   (i_predicted_value),
        .o_valid  (front_valid),
        .o_item   (front_item)
    );

    // Magnitude divided by the bound. Unpredictable items pass through it
    // with a meaningless quotient that the back end ignores.
    elq_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    // Bin state, offset code and reconstruction around the prediction.
    elq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (div_valid),
        .i_item          (div_item),
        .o_strobe        (o_strobe),
        .o_quant_code    (o_quant_code),
        .o_reconstructed (o_reconstructed),
        .o_unpredictable (o_unpredictable)
    );

endmodule

>>> rtl/elq_checker.sv
// ============================================================================
// elq_checker: port-level checks of the quantizer
// Watches the top-level ports for result timing and outlier handling.
// ============================================================================
module elq_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic signed [elq_pkg::DATA_WIDTH-1:0]  i_sample_value,
    input logic                                   o_strobe,
    input logic [elq_pkg::CODE_W-1:0]             o_quant_code,
    input logic signed [elq_pkg::RECON_W-1:0]     o_reconstructed,
    input logic                                   o_unpredictable
);

    localparam int LAT = elq_pkg::LATENCY;

    // Every result belongs to a transfer made a fixed latency earlier.
    a_result_has_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without a matching input transfer");

    // An outlier always carries code zero.
    a_outlier_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_unpredictable) |-> (o_quant_code == '0))
        else $error("unpredictable result with nonzero code");

    // An outlier passes its own sample through unchanged.
    a_outlier_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_unpredictable) |->
            (o_reconstructed == elq_pkg::RECON_W'($past(i_sample_value, LAT))))
        else $error("unpredictable result does not return the sample");

endmodule

bind error_bounded_linear_quantizer elq_checker u_elq_checker (.*);
